// ----- rtl/llex_pkg.sv -----
// Shared types and constants for the line lexer token stream.
`default_nettype none
package llex_pkg;

  // Lexer mode kept between characters of a line
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_WORD  = 3'd2,
    MODE_STR   = 3'd3,
    MODE_MINUS = 3'd4
  } llex_mode_t;

  // Token kinds carried on each result item
  typedef enum logic [3:0] {
    KIND_NUM    = 4'd0,
    KIND_STR    = 4'd1,
    KIND_COMMA  = 4'd2,
    KIND_LPAREN = 4'd3,
    KIND_RPAREN = 4'd4,
    KIND_EQ     = 4'd5,
    KIND_WORD   = 4'd6,
    KIND_UNEXP  = 4'd7,
    KIND_UNTERM = 4'd8,
    KIND_END    = 4'd9
  } llex_kind_t;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Most result items one input item can cause
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QFILL_W = QPTR_W + 1;

  typedef struct packed {
    llex_kind_t  kind;
    logic [7:0]  text;
    logic        valid;
    logic        done;
  } llex_res_t;

  // All result items caused by one input item
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    llex_res_t [MAX_RES-1:0]  res;
  } llex_bundle_t;

endpackage
`default_nettype wire

// ----- rtl/llex_front.sv -----
// Front end: accepts characters, updates the lexer mode and builds result bundles.
`default_nettype none
module llex_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            char_byte,
  input  logic                  char_present,
  input  logic                  line_end,
  input  logic                  q_full,
  output logic                  push,
  output llex_pkg::llex_bundle_t push_data
);
  import llex_pkg::*;

  llex_mode_t   mode, mode_next;
  llex_bundle_t b;

  // Append one result to a bundle
  function automatic llex_bundle_t put(input llex_bundle_t bi, input llex_kind_t k,
                                       input logic [7:0] c, input logic v, input logic d);
    llex_bundle_t bo;
    bo = bi;
    if (bi.count < CNT_W'(MAX_RES)) begin
      bo.res[bi.count[IDX_W-1:0]].kind  = k;
      bo.res[bi.count[IDX_W-1:0]].text  = v ? c : 8'h00;
      bo.res[bi.count[IDX_W-1:0]].valid = v;
      bo.res[bi.count[IDX_W-1:0]].done  = d;
      bo.count = bi.count + CNT_W'(1);
    end
    return bo;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  always_comb begin
    logic consumed;
    b         = '0;
    mode_next = mode;
    consumed  = 1'b0;
    if (char_present) begin
      case (mode)
        MODE_STR: begin
          consumed = 1'b1;
          if (char_byte == CH_QUOTE) begin
            b = put(b, KIND_STR, 8'h00, 1'b0, 1'b1);
            mode_next = MODE_IDLE;
          end else begin
            b = put(b, KIND_STR, char_byte, 1'b1, 1'b0);
          end
        end
        MODE_NUM: begin
          if (is_digit(char_byte) || char_byte == CH_DOT) begin
            b = put(b, KIND_NUM, char_byte, 1'b1, 1'b0);
            consumed = 1'b1;
          end else begin
            b = put(b, KIND_NUM, 8'h00, 1'b0, 1'b1);
          end
        end
        MODE_WORD: begin
          if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_UNDER) begin
            b = put(b, KIND_WORD, char_byte, 1'b1, 1'b0);
            consumed = 1'b1;
          end else begin
            b = put(b, KIND_WORD, 8'h00, 1'b0, 1'b1);
          end
        end
        MODE_MINUS: begin
          if (is_digit(char_byte)) begin
            b = put(b, KIND_NUM, CH_MINUS, 1'b1, 1'b0);
            b = put(b, KIND_NUM, char_byte, 1'b1, 1'b0);
            mode_next = MODE_NUM;
            consumed = 1'b1;
          end else begin
            b = put(b, KIND_UNEXP, CH_MINUS, 1'b1, 1'b1);
          end
        end
        default: ;
      endcase
      if (!consumed) begin
        mode_next = MODE_IDLE;
        if (is_space(char_byte)) begin
          mode_next = MODE_IDLE;
        end else if (is_digit(char_byte)) begin
          b = put(b, KIND_NUM, char_byte, 1'b1, 1'b0);
          mode_next = MODE_NUM;
        end else if (char_byte == CH_MINUS) begin
          mode_next = MODE_MINUS;
        end else if (char_byte == CH_QUOTE) begin
          mode_next = MODE_STR;
        end else if (char_byte == CH_COMMA) begin
          b = put(b, KIND_COMMA, char_byte, 1'b1, 1'b1);
        end else if (char_byte == CH_LPAREN) begin
          b = put(b, KIND_LPAREN, char_byte, 1'b1, 1'b1);
        end else if (char_byte == CH_RPAREN) begin
          b = put(b, KIND_RPAREN, char_byte, 1'b1, 1'b1);
        end else if (char_byte == CH_EQ) begin
          b = put(b, KIND_EQ, char_byte, 1'b1, 1'b1);
        end else if (is_alpha(char_byte) || char_byte == CH_UNDER) begin
          b = put(b, KIND_WORD, char_byte, 1'b1, 1'b0);
          mode_next = MODE_WORD;
        end else begin
          b = put(b, KIND_UNEXP, char_byte, 1'b1, 1'b1);
        end
      end
    end
    if (line_end) begin
      case (mode_next)
        MODE_NUM:   b = put(b, KIND_NUM, 8'h00, 1'b0, 1'b1);
        MODE_WORD:  b = put(b, KIND_WORD, 8'h00, 1'b0, 1'b1);
        MODE_STR:   b = put(b, KIND_UNTERM, 8'h00, 1'b0, 1'b1);
        MODE_MINUS: b = put(b, KIND_UNEXP, CH_MINUS, 1'b1, 1'b1);
        default: ;
      endcase
      b = put(b, KIND_END, 8'h00, 1'b0, 1'b1);
      mode_next = MODE_IDLE;
    end
  end

  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready && (b.count != '0);
  assign push_data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (in_valid && in_ready) begin
      mode <= mode_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/llex_queue.sv -----
// Short bundle queue between the lexer front end and the result serialiser.
`default_nettype none
module llex_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  llex_pkg::llex_bundle_t push_data,
  input  logic                   pop,
  output llex_pkg::llex_bundle_t head,
  output logic                   not_empty,
  output logic                   full
);
  import llex_pkg::*;

  llex_bundle_t        entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QFILL_W-1:0]  fill;

  assign head      = entries[rd_ptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == QFILL_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/llex_back.sv -----
// Back end: walks the head bundle and hands out one result item per cycle while the receiver is ready.
`default_nettype none
module llex_back (
  input  logic                   clk,
  input  logic                   rst,
  input  llex_pkg::llex_bundle_t head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output llex_pkg::llex_res_t    out_res,
  output logic                   out_last
);
  import llex_pkg::*;

  logic [IDX_W-1:0] idx;

  assign out_valid = head_valid;
  assign out_res   = head.res[idx];
  assign out_last  = ({1'b0, idx} == (head.count - CNT_W'(1)));
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= out_last ? '0 : idx + IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/line_lexer_token_stream_core.sv -----
// Top level of the streaming line lexer: front end, bundle queue and back end.
// An accepted character's bundle is registered in the bundle queue and shown from its head.
// Throughput: one character per cycle while the four-deep bundle queue has room; the
// output side gives one result item per cycle while the receiver is ready, so a character
// that causes several items holds the output until all are taken (at most four).
// Reset (rst, synchronous, active high) returns the lexer to idle and empties the queue.
`default_nettype none
module line_lexer_token_stream_core (
  input  logic       clk,
  input  logic       rst,
  // Input channel: one character of a line per item
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] char_byte
  input  logic       s_tuser,  // [0] char_present
  input  logic       s_tlast,  // line_end
  // Output channel: one token piece per item
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] text_byte
  output logic [5:0] m_tuser,  // [3:0] token_kind, [4] byte_valid, [5] token_done
  output logic       m_tlast   // last_result
);
  import llex_pkg::*;

  logic         push, pop, q_full, q_not_empty, last;
  llex_bundle_t push_data, head;
  llex_res_t    res;

  // Front end: classify the character against the current mode and build
  // every result item it causes as one bundle.
  llex_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .char_byte    (s_tdata),
    .char_present (s_tuser),
    .line_end     (s_tlast),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  // Hold bundles so the input keeps flowing while the output side stalls.
  llex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back end: hand out the bundle's items in order, flag the last one.
  llex_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res),
    .out_last   (last)
  );

  assign m_tdata = res.text;
  assign m_tuser = {res.done, res.valid, res.kind};
  assign m_tlast = last;

endmodule
`default_nettype wire

// ----- rtl/llex_checker.sv -----
// Port-level checks for the line lexer, bound to the top level.
`default_nettype none
module llex_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [5:0] m_tuser,
  input logic       m_tlast
);
  import llex_pkg::*;

  // Reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A marker item carries no text and always closes its token
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[4]) |-> (m_tuser[5] && m_tdata == 8'h00))
    else $error("marker item with text or without token end");

  // The end token is always the last item caused by its character
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:0] == KIND_END) |-> m_tlast)
    else $error("end token not flagged last");

  // Text-carrying pieces of a still-open token never close it
  a_open_piece: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[4] && (m_tuser[3:0] == KIND_NUM || m_tuser[3:0] == KIND_WORD
      || m_tuser[3:0] == KIND_STR)) |-> !m_tuser[5])
    else $error("number, word or string byte closes its token");

  // A stalled output item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast)))
    else $error("stalled output item changed");

endmodule

bind line_lexer_token_stream_core llex_checker u_llex_checker (.*);
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the streaming line lexer: table-driven and random lines.
module tb_top;
  import llex_pkg::*;

  // One token piece as it leaves the block
  typedef struct packed {
    llex_kind_t kind;
    logic [7:0] text;
    logic       valid;
    logic       done;
    logic       last;
  } piece_t;

  // One character item as it enters the block
  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       eol;
  } char_item_t;

  // Row of the directed table: n_typed < 0 means the predictor supplies the pieces
  typedef struct {
    char_item_t item;
    int         n_typed;
    piece_t     t0;
    piece_t     t1;
  } dir_row_t;

  // Shapes of token that the random line builder strings together
  typedef enum {
    SHAPE_NUM, SHAPE_WORD, SHAPE_STR, SHAPE_MARK, SHAPE_NOISE, SHAPE_DASH
  } shape_t;

  localparam int     PREDICT        = -1;
  localparam piece_t NONE           = '0;
  localparam int     RAND_ITEMS     = 85;
  localparam int     HOLD_CYCLES    = 60;
  localparam int     DRAIN_CYCLES   = 8;
  localparam int     WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [5:0] m_tuser;
  logic       m_tlast;

  // Predictor state and the pieces still owed by the block
  llex_mode_t scan_mode = MODE_IDLE;
  piece_t     step_pieces[$];
  piece_t     pending[$];

  dir_row_t   dir_rows[$];
  char_item_t line_q[$];

  int tx_idle_pct = 30;
  int rx_idle_pct = 55;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int quiet       = 0;
  int mismatches  = 0;
  int chars_sent  = 0;
  int lines_sent  = 0;
  int pieces_seen = 0;
  int rand_items  = 0;
  int phase       = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_lexer_token_stream_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Lexer predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Append one piece; markers carry a zero byte
  function void add_piece(llex_kind_t k, logic [7:0] b, logic v, logic d);
    piece_t p;
    p.kind  = k;
    p.text  = v ? b : 8'h00;
    p.valid = v;
    p.done  = d;
    p.last  = 1'b0;
    step_pieces.push_back(p);
  endfunction

  // Advance the lexer by one present character
  function void scan_char(logic [7:0] c);
    case (scan_mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          add_piece(KIND_STR, 8'h00, 1'b0, 1'b1);
          scan_mode = MODE_IDLE;
        end else begin
          add_piece(KIND_STR, c, 1'b1, 1'b0);
        end
        return;
      end
      MODE_NUM: begin
        if (is_digit(c) || c == CH_DOT) begin
          add_piece(KIND_NUM, c, 1'b1, 1'b0);
          return;
        end
        add_piece(KIND_NUM, 8'h00, 1'b0, 1'b1);
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
          add_piece(KIND_WORD, c, 1'b1, 1'b0);
          return;
        end
        add_piece(KIND_WORD, 8'h00, 1'b0, 1'b1);
      end
      MODE_MINUS: begin
        // A digit turns the pending minus into the head of a number
        if (is_digit(c)) begin
          add_piece(KIND_NUM, CH_MINUS, 1'b1, 1'b0);
          add_piece(KIND_NUM, c, 1'b1, 1'b0);
          scan_mode = MODE_NUM;
          return;
        end
        add_piece(KIND_UNEXP, CH_MINUS, 1'b1, 1'b1);
      end
      default: ;
    endcase
    // Lex the character afresh from idle
    scan_mode = MODE_IDLE;
    if (is_space(c)) begin
    end else if (is_digit(c)) begin
      add_piece(KIND_NUM, c, 1'b1, 1'b0);
      scan_mode = MODE_NUM;
    end else if (c == CH_MINUS) begin
      scan_mode = MODE_MINUS;
    end else if (c == CH_QUOTE) begin
      scan_mode = MODE_STR;
    end else if (c == CH_COMMA) begin
      add_piece(KIND_COMMA, c, 1'b1, 1'b1);
    end else if (c == CH_LPAREN) begin
      add_piece(KIND_LPAREN, c, 1'b1, 1'b1);
    end else if (c == CH_RPAREN) begin
      add_piece(KIND_RPAREN, c, 1'b1, 1'b1);
    end else if (c == CH_EQ) begin
      add_piece(KIND_EQ, c, 1'b1, 1'b1);
    end else if (is_alpha(c) || c == CH_UNDER) begin
      add_piece(KIND_WORD, c, 1'b1, 1'b0);
      scan_mode = MODE_WORD;
    end else begin
      add_piece(KIND_UNEXP, c, 1'b1, 1'b1);
    end
  endfunction

  // Close whatever token is open, then the line itself
  function void close_line();
    case (scan_mode)
      MODE_NUM:   add_piece(KIND_NUM, 8'h00, 1'b0, 1'b1);
      MODE_WORD:  add_piece(KIND_WORD, 8'h00, 1'b0, 1'b1);
      MODE_STR:   add_piece(KIND_UNTERM, 8'h00, 1'b0, 1'b1);
      MODE_MINUS: add_piece(KIND_UNEXP, CH_MINUS, 1'b1, 1'b1);
      default: ;
    endcase
    add_piece(KIND_END, 8'h00, 1'b0, 1'b1);
    scan_mode = MODE_IDLE;
  endfunction

  // Work out every piece that one accepted item causes
  function void predict_item(char_item_t it);
    step_pieces.delete();
    if (it.present) scan_char(it.ch);
    if (it.eol) close_line();
    if (step_pieces.size() > 0) step_pieces[step_pieces.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A closing piece typed in by hand: a single mark, an error or a marker
  function automatic piece_t mark(llex_kind_t k, logic v, logic [7:0] b);
    piece_t p;
    p.kind  = k;
    p.text  = v ? b : 8'h00;
    p.valid = v;
    p.done  = 1'b1;
    p.last  = 1'b0;
    return p;
  endfunction

  function void add_row(logic [7:0] c, logic p, logic e, int n, piece_t t0, piece_t t1);
    dir_row_t r;
    r.item    = '{c, p, e};
    r.n_typed = n;
    r.t0      = t0;
    r.t1      = t1;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alpha();
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_tail();
    case ($urandom_range(0, 3))
      0:       return rand_digit();
      1:       return CH_UNDER;
      default: return rand_alpha();
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  // Any byte but the closing quote
  function automatic logic [7:0] rand_str_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CH_QUOTE) ? CH_SPACE : c;
  endfunction

  function void push_char(logic [7:0] c);
    line_q.push_back('{c, 1'b1, 1'b0});
  endfunction

  // Build one source line: mostly well-formed tokens with random content,
  // laced with stray bytes, lone minus signs and open strings
  task automatic gen_line();
    int     n_tok;
    shape_t shape;
    bit     open_str;
    line_q.delete();
    n_tok    = $urandom_range(1, 5);
    open_str = 1'b0;
    for (int t = 0; t < n_tok && !open_str; t++) begin
      shape = shape_t'($urandom_range(0, 5));
      case (shape)
        SHAPE_NUM: begin
          if ($urandom_range(0, 2) == 0) push_char(CH_MINUS);
          push_char(rand_digit());
          repeat ($urandom_range(0, 3))
            push_char(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
        end
        SHAPE_WORD: begin
          push_char(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_alpha());
          repeat ($urandom_range(0, 3)) push_char(rand_tail());
        end
        SHAPE_STR: begin
          push_char(CH_QUOTE);
          repeat ($urandom_range(0, 3)) push_char(rand_str_char());
          // Leave some strings open so the line ends inside them
          if ($urandom_range(0, 3) == 0) open_str = 1'b1;
          else push_char(CH_QUOTE);
        end
        SHAPE_MARK: begin
          case ($urandom_range(0, 3))
            0:       push_char(CH_COMMA);
            1:       push_char(CH_LPAREN);
            2:       push_char(CH_RPAREN);
            default: push_char(CH_EQ);
          endcase
        end
        SHAPE_NOISE: push_char(8'($urandom_range(0, 255)));
        default:     push_char(CH_MINUS);
      endcase
      if ($urandom_range(0, 1)) push_char(rand_space());
      // An empty item now and then: the block must ignore it
      if ($urandom_range(0, 19) == 0) line_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
    end
    // Close the line on its last character or on a separate empty item
    if ($urandom_range(0, 2) == 0) line_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    else line_q[line_q.size() - 1].eol = 1'b1;
  endtask

  // Offer one item, wait for the handshake, then log what it should cause
  task automatic send_item(char_item_t it, int n_typed, piece_t t0, piece_t t1);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.ch;
    s_tuser  <= it.present;
    s_tlast  <= it.eol;
    do @(posedge clk); while (!s_tready);
    // Always advance the predictor so its mode follows the block
    predict_item(it);
    if (n_typed >= 0) begin
      step_pieces.delete();
      if (n_typed > 0) step_pieces.push_back(t0);
      if (n_typed > 1) step_pieces.push_back(t1);
      if (n_typed > 0) step_pieces[n_typed - 1].last = 1'b1;
    end
    foreach (step_pieces[k]) pending.push_back(step_pieces[k]);
    if (it.present) chars_sent++;
    if (it.eol) lines_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    piece_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (m_tvalid && m_tready) begin
        pieces_seen++;
        if (pending.size() == 0) begin
          $error("unexpected result item: kind %0d byte %02h", m_tuser[3:0], m_tdata);
          mismatches++;
        end else begin
          want = pending.pop_front();
          if (m_tuser[3:0] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_tuser[3:0]);
            mismatches++;
          end
          if (m_tdata !== want.text) begin
            $error("text_byte: expected %02h, got %02h", want.text, m_tdata);
            mismatches++;
          end
          if (m_tuser[4] !== want.valid) begin
            $error("byte_valid: expected %0b, got %0b", want.valid, m_tuser[4]);
            mismatches++;
          end
          if (m_tuser[5] !== want.done) begin
            $error("token_done: expected %0b, got %0b", want.done, m_tuser[5]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timed out: no item moved for %0d cycles, %0d pieces outstanding",
                 WATCHDOG_LIMIT, pending.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hand-typed rows hold results that are obvious; the rest go to the predictor
    add_row(8'h00, 1'b0, 1'b0, 0, NONE, NONE);                      // empty item: nothing
    add_row(CH_SPACE, 1'b1, 1'b1, 1, mark(KIND_END, 1'b0, 8'h00), NONE);
    add_row(8'h00, 1'b1, 1'b0, 1, mark(KIND_UNEXP, 1'b1, 8'h00), NONE);  // NUL is stray
    add_row(8'hFF, 1'b1, 1'b0, 1, mark(KIND_UNEXP, 1'b1, 8'hFF), NONE);  // high bytes too
    add_row(CH_COMMA, 1'b1, 1'b0, 1, mark(KIND_COMMA, 1'b1, CH_COMMA), NONE);
    add_row(CH_LPAREN, 1'b1, 1'b0, 1, mark(KIND_LPAREN, 1'b1, CH_LPAREN), NONE);
    add_row(CH_RPAREN, 1'b1, 1'b0, 1, mark(KIND_RPAREN, 1'b1, CH_RPAREN), NONE);
    add_row(CH_EQ, 1'b1, 1'b0, 1, mark(KIND_EQ, 1'b1, CH_EQ), NONE);
    // Number, then a word that closes it, then a minus that closes the word
    add_row("1", 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(CH_DOT, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row("x", 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(CH_UNDER, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row("9", 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(CH_MINUS, 1'b1, 1'b0, PREDICT, NONE, NONE);
    // Minus followed by minus: the first is stray, the second waits on
    add_row(CH_MINUS, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row("5", 1'b1, 1'b0, PREDICT, NONE, NONE);
    // Opening quote closes the number and gives nothing of its own
    add_row(CH_QUOTE, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row("z", 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(CH_QUOTE, 1'b1, 1'b0, PREDICT, NONE, NONE);
    // Minus at line end
    add_row(CH_MINUS, 1'b1, 1'b1, 2, mark(KIND_UNEXP, 1'b1, CH_MINUS),
            mark(KIND_END, 1'b0, 8'h00));
    // Line ending inside a string
    add_row(CH_QUOTE, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(8'h09, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row(8'h00, 1'b0, 1'b1, 2, mark(KIND_UNTERM, 1'b0, 8'h00),
            mark(KIND_END, 1'b0, 8'h00));
    // Signed digit at line end: four pieces from one item
    add_row(CH_MINUS, 1'b1, 1'b0, PREDICT, NONE, NONE);
    add_row("7", 1'b1, 1'b1, PREDICT, NONE, NONE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].t0,
                                    dir_rows[i].t1);

    // Random lines; swap the idle pattern a third of the way in, then stop idling
    // and hold the output long enough for the input to back up
    while (rand_items < RAND_ITEMS) begin
      gen_line();
      foreach (line_q[k]) begin
        if (phase == 0 && rand_items >= RAND_ITEMS / 3) begin
          phase       = 1;
          tx_idle_pct = 55;
          rx_idle_pct = 30;
        end
        if (phase == 1 && rand_items >= 2 * RAND_ITEMS / 3) begin
          phase       = 2;
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
        send_item(line_q[k], PREDICT, NONE, NONE);
        if (line_q[k].present || line_q[k].eol) rand_items++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a few cycles for any stray piece to show up
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d characters over %0d lines: %0d table rows, then random lines",
             chars_sent, lines_sent, dir_rows.size());
    $display("under three stall patterns and one long output hold; %0d pieces checked, %0d bad",
             pieces_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
